// ===== rtl/path_glob_matcher_defines.svh =====
// Assertion macros used by the glob matcher top level.
// Depends on a clk and rst signal in the scope of each use.
`ifndef PATH_GLOB_MATCHER_DEFINES_SVH
`define PATH_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PGM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pgm_pkg.sv =====
// Shared types and constants for the glob matcher.
// No dependencies.
package pgm_pkg;

  // Request kinds carried on s_tuser
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_PATH   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  localparam logic [7:0] SYM_STAR     = 8'h2A;
  localparam logic [7:0] SYM_QUESTION = 8'h3F;
  localparam logic [7:0] SYM_SLASH    = 8'h2F;

  // Pattern store control
  typedef struct packed {
    logic clear;
    logic append;
  } pat_ctrl_t;

  // Active-prefix vector control
  typedef struct packed {
    logic restart;
    logic step;
  } nfa_ctrl_t;

endpackage

// ===== rtl/pgm_pattern.sv =====
// Pattern store: bytes, length, slash and overflow flags, per-entry match vectors.
// Depends on pgm_pkg.
module pgm_pattern #(
  parameter int PATTERN_MAX = 32,
  localparam int LW = $clog2(PATTERN_MAX + 1),
  localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pgm_pkg::pat_ctrl_t     ctrl,
  input  logic [7:0]             sym,
  output logic [PATTERN_MAX-1:0] star_vec,
  output logic [PATTERN_MAX-1:0] match_vec,
  output logic [LW-1:0]          length,
  output logic                   has_slash,
  output logic                   overflow
);

  logic [7:0] store [PATTERN_MAX];
  logic       full;

  assign full = (length == LW'(PATTERN_MAX));

  // Length and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      has_slash <= 1'b0;
      overflow  <= 1'b0;
    end else if (ctrl.clear) begin
      length    <= '0;
      has_slash <= 1'b0;
      overflow  <= 1'b0;
    end else if (ctrl.append) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        length <= length + LW'(1);
      end
      if (sym == pgm_pkg::SYM_SLASH) begin
        has_slash <= 1'b1;
      end
    end
  end

  // Byte store, written at the current length
  always_ff @(posedge clk) begin
    if (ctrl.append && !full) begin
      store[length[AW-1:0]] <= sym;
    end
  end

  // Per-entry star and single-byte match, masked to the loaded length
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      logic live;
      logic is_star;
      live         = (LW'(i) < length);
      is_star      = (store[i] == pgm_pkg::SYM_STAR);
      star_vec[i]  = live & is_star;
      match_vec[i] = live & !is_star &
                     ((store[i] == pgm_pkg::SYM_QUESTION) || (store[i] == sym));
    end
  end

endmodule

// ===== rtl/pgm_nfa.sv =====
// Active-prefix vector with star closure and one-byte advance.
// Depends on pgm_pkg; fed by pgm_pattern.
module pgm_nfa #(
  parameter int PATTERN_MAX = 32,
  localparam int LW = $clog2(PATTERN_MAX + 1),
  localparam int VW = PATTERN_MAX + 1,
  localparam int LEVELS = $clog2(VW)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pgm_pkg::nfa_ctrl_t     ctrl,
  input  logic [PATTERN_MAX-1:0] star_vec,
  input  logic [PATTERN_MAX-1:0] match_vec,
  input  logic [LW-1:0]          length,
  output logic                   hit
);

  // Held without closure; closure is applied against the current pattern
  logic [VW-1:0] active;
  logic [VW-1:0] active_next;
  logic [VW-1:0] closed;
  logic [VW-1:0] stepped;

  // Star closure as a parallel prefix: bit j inherits bit j-1 across a star
  always_comb begin : closure_blk
    logic [VW-1:0] g;
    logic [VW-1:0] p;
    logic [VW-1:0] gn;
    logic [VW-1:0] pn;
    int d;
    g = active;
    p = {star_vec, 1'b0};
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      d  = 1 << lvl;
      gn = g;
      pn = p;
      for (int j = 0; j < VW; j++) begin
        if (j >= d) begin
          gn[j] = g[j] | (p[j] & g[j-d]);
          pn[j] = p[j] & p[j-d];
        end
      end
      g = gn;
      p = pn;
    end
    closed = g;
  end

  // One byte: a star holds its prefix, a matching entry moves it forward
  always_comb begin
    for (int j = 0; j < VW; j++) begin
      stepped[j] = 1'b0;
      if (j < PATTERN_MAX) begin
        stepped[j] = stepped[j] | (closed[j] & star_vec[j]);
      end
      if (j > 0) begin
        stepped[j] = stepped[j] | (closed[j-1] & match_vec[j-1]);
      end
    end
  end

  always_comb begin
    active_next = active;
    if (ctrl.restart) begin
      active_next = VW'(1);
    end else if (ctrl.step) begin
      active_next = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= VW'(1);
    end else begin
      active <= active_next;
    end
  end

  assign hit = closed[length];

endmodule

// ===== rtl/path_glob_matcher.sv =====
// Glob matcher top level: stream handshake, request decode, result register.
// Depends on pgm_pkg, pgm_pattern, pgm_nfa and path_glob_matcher_defines.svh.
//
//   port group | dir | tdata            | tuser     | carries
//   s_*        | in  | symbol[7:0]      | kind[1:0] | pattern bytes, path bytes, markers
//   m_*        | out | matched, error   | -         | one result per end-of-path
//
// One request per cycle while s_tready is high; the result of an end-of-path
// request is in m_tdata the cycle after it is taken. The limit is the prefix-vector
// update: star closure (log2 of PATTERN_MAX+1 levels) plus one advance step per byte.
// Reset (rst, synchronous) empties the pattern and drops any pending result.
// A held result stalls s_tready only if m_tready is low at the same time.
`include "path_glob_matcher_defines.svh"

module path_glob_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic [1:0] s_tuser,   // [1:0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] pattern_error, [7:2] zero
);

  localparam int LW = $clog2(PATTERN_MAX + 1);

  pgm_pkg::kind_t     kind;
  pgm_pkg::pat_ctrl_t pat_ctrl;
  pgm_pkg::nfa_ctrl_t nfa_ctrl;
  logic                   s_acc;
  logic                   slash_restart;
  logic [PATTERN_MAX-1:0] star_vec;
  logic [PATTERN_MAX-1:0] match_vec;
  logic [LW-1:0]          pat_len;
  logic                   pat_slash;
  logic                   pat_overflow;
  logic                   hit;
  logic                   matched;
  logic                   pattern_error;

  assign kind     = pgm_pkg::kind_t'(s_tuser);
  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;

  // Request decode
  assign slash_restart = (kind == pgm_pkg::KIND_PATH) &&
                         (s_tdata == pgm_pkg::SYM_SLASH) && !pat_slash;

  always_comb begin
    pat_ctrl.clear   = s_acc && (kind == pgm_pkg::KIND_CLEAR);
    pat_ctrl.append  = s_acc && (kind == pgm_pkg::KIND_APPEND);
    nfa_ctrl.restart = s_acc && ((kind == pgm_pkg::KIND_CLEAR)  ||
                                 (kind == pgm_pkg::KIND_APPEND) ||
                                 (kind == pgm_pkg::KIND_END)    || slash_restart);
    nfa_ctrl.step    = s_acc && (kind == pgm_pkg::KIND_PATH) && !slash_restart;
  end

  pgm_pattern #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_pattern (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (pat_ctrl),
    .sym       (s_tdata),
    .star_vec  (star_vec),
    .match_vec (match_vec),
    .length    (pat_len),
    .has_slash (pat_slash),
    .overflow  (pat_overflow)
  );

  pgm_nfa #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_nfa (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (nfa_ctrl),
    .star_vec  (star_vec),
    .match_vec (match_vec),
    .length    (pat_len),
    .hit       (hit)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc && (kind == pgm_pkg::KIND_END)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && (kind == pgm_pkg::KIND_END)) begin
      matched       <= hit && !pat_overflow;
      pattern_error <= pat_overflow;
    end
  end

  assign m_tdata = {6'b0, pattern_error, matched};

  // Checks
  `PGM_ASSERT_NOW(a_match_no_error, m_tvalid && m_tdata[0], !m_tdata[1], "match reported with overflowed pattern")
  `PGM_ASSERT_NEXT(a_end_gives_result, s_acc && (kind == pgm_pkg::KIND_END), m_tvalid, "end of path gave no result")
  `PGM_ASSERT_NEXT(a_no_spurious_result, s_acc && (kind != pgm_pkg::KIND_END) && (!m_tvalid || m_tready), !m_tvalid, "result without end of path")
  `PGM_ASSERT_NOW(a_overflow_full, pat_overflow, pat_len == LW'(PATTERN_MAX), "overflow with store not full")

endmodule
